// ===== hw/rtl/stpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpg_pkg: shared types and constants for the step pulse generator
// Operation codes, register indexes, reset values and the structs passed
// between the move planner, the phase timer and the top level.
// ----------------------------------------------------------------------------
package stpg_pkg;

  // Input operation codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_MOVE   = 3'd1,
    OP_GOTO   = 3'd2,
    OP_ZERO   = 3'd3,
    OP_ENABLE = 3'd4
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_HIGH_TICKS  = 2'd0;
  localparam logic [1:0] CFG_STEP_PERIOD = 2'd1;
  localparam logic [1:0] CFG_LOWER_BOUND = 2'd2;
  localparam logic [1:0] CFG_UPPER_BOUND = 2'd3;

  // Configuration reset values
  localparam logic [15:0]        RESET_HIGH_TICKS  = 16'd750;
  localparam logic [15:0]        RESET_STEP_PERIOD = 16'd760;
  localparam logic signed [15:0] RESET_LOWER_BOUND = 16'sh8000;
  localparam logic signed [15:0] RESET_UPPER_BOUND = 16'sh7FFF;

  // Planned move from a relative move or go-to command
  typedef struct packed {
    logic        start;   // a move takes effect
    logic        dir;     // 1 counts position up
    logic [15:0] steps;   // clamped step count
  } move_t;

  // Phase timer result for one tick
  typedef struct packed {
    logic        active;
    logic        pulse_high;
    logic [15:0] countdown;
    logic        step;    // rising edge: take one step
  } tick_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stepper_step_pulse_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator: step/direction pulse generator, one motor
// Each input transfer is a timer tick or a command (relative move, go-to,
// zero position, set enable); each one yields one result transfer holding
// the pin levels, position, remaining steps and busy flag after it.
//
// Channels: input (in_valid/in_ready), result (out_valid/out_ready) and a
// configuration write port (cfg_valid/cfg_ready, cfg_index, cfg_data) that
// is always ready; write it only while no item is in flight.
// Pipeline: the input register, then the result register; the motor state
// is updated as an item moves from the first to the second. Throughput: one
// item per cycle while out_ready stays high, set by the single state update
// between the input register and the result register.
// Stall: the result register holds while out_ready is low; the input
// register takes one more item, then in_ready drops until the result
// moves on.
// Reset (rst, synchronous): registers go to their reset values, position
// and steps clear, pin low, driver disabled, both pipeline stages empty.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         operation,
  input  wire logic               move_dir,
  input  wire logic [15:0]        step_count,
  input  wire logic signed [15:0] target_position,
  input  wire logic               enable_flag,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    step_pin,
  output logic                    dir_pin,
  output logic                    enable_pin_n,
  output logic signed [15:0]      current_position,
  output logic [15:0]             steps_left,
  output logic                    busy_res,
  // Configuration port
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // Configuration registers
  logic [15:0]        high_ticks;
  logic [15:0]        step_period;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;

  // Input register
  logic               s1_valid;
  logic [2:0]         s1_operation;
  logic               s1_move_dir;
  logic [15:0]        s1_step_count;
  logic signed [15:0] s1_target;
  logic               s1_enable_flag;
  logic               s1_advance;

  // Motor state
  logic [POSITION_BITS-1:0] position_count;
  logic [POSITION_BITS-1:0] position_count_next;
  logic [15:0]              remaining_steps;
  logic [15:0]              remaining_steps_next;
  logic [15:0]              phase_countdown;
  logic [15:0]              phase_countdown_next;
  logic                     pulse_high;
  logic                     pulse_high_next;
  logic                     active;
  logic                     active_next;
  logic                     direction_bit;
  logic                     direction_bit_next;
  logic                     driver_enabled;
  logic                     driver_enabled_next;

  stpg_pkg::op_t   op;
  stpg_pkg::move_t move;
  stpg_pkg::tick_t tick;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign op         = stpg_pkg::op_t'(s1_operation);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_ticks  <= stpg_pkg::RESET_HIGH_TICKS;
      step_period <= stpg_pkg::RESET_STEP_PERIOD;
      lower_bound <= stpg_pkg::RESET_LOWER_BOUND;
      upper_bound <= stpg_pkg::RESET_UPPER_BOUND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        stpg_pkg::CFG_HIGH_TICKS:  high_ticks  <= cfg_data;
        stpg_pkg::CFG_STEP_PERIOD: step_period <= cfg_data;
        stpg_pkg::CFG_LOWER_BOUND: lower_bound <= signed'(cfg_data);
        stpg_pkg::CFG_UPPER_BOUND: upper_bound <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_operation   <= operation;
      s1_move_dir    <= move_dir;
      s1_step_count  <= step_count;
      s1_target      <= target_position;
      s1_enable_flag <= enable_flag;
    end
  end

  stpg_move #(
    .PosBits (POSITION_BITS)
  ) u_move (
    .position        (position_count),
    .is_goto         (op == stpg_pkg::OP_GOTO),
    .move_dir        (s1_move_dir),
    .step_count      (s1_step_count),
    .target_position (s1_target),
    .lower_bound     (lower_bound),
    .upper_bound     (upper_bound),
    .move            (move)
  );

  stpg_timer u_timer (
    .active        (active),
    .pulse_high    (pulse_high),
    .countdown     (phase_countdown),
    .steps_pending (remaining_steps != '0),
    .high_ticks    (high_ticks),
    .step_period   (step_period),
    .tick          (tick)
  );

  // Apply one item to the motor state
  always_comb begin
    position_count_next  = position_count;
    remaining_steps_next = remaining_steps;
    phase_countdown_next = phase_countdown;
    pulse_high_next      = pulse_high;
    active_next          = active;
    direction_bit_next   = direction_bit;
    driver_enabled_next  = driver_enabled;
    unique case (op) inside
      stpg_pkg::OP_TICK: begin
        active_next          = tick.active;
        pulse_high_next      = tick.pulse_high;
        phase_countdown_next = tick.countdown;
        if (tick.step) begin
          remaining_steps_next = remaining_steps - 16'd1;
          position_count_next  = direction_bit ?
                                 (position_count + POSITION_BITS'(1)) :
                                 (position_count - POSITION_BITS'(1));
        end
      end
      stpg_pkg::OP_MOVE, stpg_pkg::OP_GOTO: begin
        if (move.start) begin
          direction_bit_next   = move.dir;
          remaining_steps_next = move.steps;
          if (!active) begin
            active_next          = 1'b1;
            phase_countdown_next = 16'd1;
          end
        end
      end
      stpg_pkg::OP_ZERO:   position_count_next = '0;
      stpg_pkg::OP_ENABLE: driver_enabled_next = s1_enable_flag;
      default: ;
    endcase
  end

  // Hold motor state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count  <= '0;
      remaining_steps <= '0;
      phase_countdown <= '0;
      pulse_high      <= 1'b0;
      active          <= 1'b0;
      direction_bit   <= 1'b0;
      driver_enabled  <= 1'b0;
    end else if (s1_advance) begin
      position_count  <= position_count_next;
      remaining_steps <= remaining_steps_next;
      phase_countdown <= phase_countdown_next;
      pulse_high      <= pulse_high_next;
      active          <= active_next;
      direction_bit   <= direction_bit_next;
      driver_enabled  <= driver_enabled_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      step_pin         <= pulse_high_next;
      dir_pin          <= direction_bit_next;
      enable_pin_n     <= !driver_enabled_next;
      current_position <= signed'(16'(position_count_next));
      steps_left       <= remaining_steps_next;
      busy_res         <= active_next;
    end
  end

  // The phase countdown runs exactly while the block is active
  assert property (@(posedge clk) disable iff (rst)
    active == (phase_countdown != '0))
    else $error("phase countdown disagrees with active flag");

  // A high step pin only occurs during an active move
  assert property (@(posedge clk) disable iff (rst)
    pulse_high |-> active)
    else $error("step pin high while idle");

  // A stalled result with a queued item blocks new input
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s1_valid) |-> !in_ready)
    else $error("input accepted while both stages are full");

  // A state update always produces a result
  assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("state updated without a result");

endmodule
`default_nettype wire

// ===== hw/rtl/stpg_move.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpg_move: move planner
// Turns a relative move or a go-to target into a direction and a step
// count clamped so that the position stays within the configured bounds.
// ----------------------------------------------------------------------------
module stpg_move #(
  parameter int PosBits = 16
) (
  input  wire logic [PosBits-1:0] position,
  input  wire logic               is_goto,
  input  wire logic               move_dir,
  input  wire logic [15:0]        step_count,
  input  wire logic signed [15:0] target_position,
  input  wire logic signed [15:0] lower_bound,
  input  wire logic signed [15:0] upper_bound,
  output stpg_pkg::move_t         move
);

  localparam int W = ((PosBits > 16) ? PosBits : 16) + 2;

  logic signed [W-1:0] pos_w;
  logic signed [W-1:0] target_w;
  logic signed [W-1:0] lower_w;
  logic signed [W-1:0] upper_w;
  logic signed [W-1:0] span;
  logic signed [W-1:0] limit;
  logic signed [W-1:0] req_w;
  logic                goto_up;
  logic [15:0]         goto_steps;
  logic                req_dir;
  logic [15:0]         req_steps;

  assign pos_w    = W'(signed'(position));
  assign target_w = W'(target_position);
  assign lower_w  = W'(lower_bound);
  assign upper_w  = W'(upper_bound);

  // Derive direction and saturated distance for a go-to
  assign goto_up    = target_w > pos_w;
  assign span       = goto_up ? (target_w - pos_w) : (pos_w - target_w);
  assign goto_steps = (span[W-1:16] != '0) ? 16'hFFFF : span[15:0];

  assign req_dir   = is_goto ? goto_up : move_dir;
  assign req_steps = is_goto ? goto_steps : step_count;
  assign req_w     = signed'({{(W-16){1'b0}}, req_steps});

  // Room left before the bound in the move direction
  assign limit = req_dir ? (upper_w - pos_w) : (pos_w - lower_w);

  // Clamp the count; a position already past the bound gives zero
  always_comb begin
    move.start = !is_goto || (target_w != pos_w);
    move.dir   = req_dir;
    if (limit < 0) begin
      move.steps = '0;
    end else if (req_w > limit) begin
      move.steps = limit[15:0];
    end else begin
      move.steps = req_steps;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/stpg_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpg_timer: step phase timer
// Counts down the current phase on each tick and, at the compare event,
// alternates between the high and low phase or ends the move.
// ----------------------------------------------------------------------------
module stpg_timer (
  input  wire logic        active,
  input  wire logic        pulse_high,
  input  wire logic [15:0] countdown,
  input  wire logic        steps_pending,
  input  wire logic [15:0] high_ticks,
  input  wire logic [15:0] step_period,
  output stpg_pkg::tick_t  tick
);

  logic [15:0] high_time;
  logic [15:0] low_time;

  // Hold high time at 1 minimum; low time is the rest of the period, or 1 if the period is not longer
  assign high_time = (high_ticks == '0) ? 16'd1 : high_ticks;
  assign low_time  = (step_period > high_time) ? (step_period - high_time) : 16'd1;

  always_comb begin
    tick.active     = active;
    tick.pulse_high = pulse_high;
    tick.countdown  = countdown;
    tick.step       = 1'b0;
    if (active) begin
      if (countdown > 16'd1) begin
        // Advance the running phase
        tick.countdown = countdown - 16'd1;
      end else if (!steps_pending) begin
        // Drop the pin and go idle
        tick.active     = 1'b0;
        tick.pulse_high = 1'b0;
        tick.countdown  = '0;
      end else if (pulse_high) begin
        tick.pulse_high = 1'b0;
        tick.countdown  = low_time;
      end else begin
        tick.pulse_high = 1'b1;
        tick.countdown  = high_time;
        tick.step       = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/stpg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpg_checker: result predictor and scoreboard for the step pulse generator
// Watches the input, result and configuration channels. Each input transfer
// runs through a local model of the motor state (position, remaining steps,
// phase timer, pin levels), and the predicted pin set is queued. Each result
// transfer is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module stpg_checker #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         operation,
  input  logic               move_dir,
  input  logic [15:0]        step_count,
  input  logic signed [15:0] target_position,
  input  logic               enable_flag,
  // Result channel
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               step_pin,
  input  logic               dir_pin,
  input  logic               enable_pin_n,
  input  logic signed [15:0] current_position,
  input  logic [15:0]        steps_left,
  input  logic               busy_res,
  // Configuration port
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // Status toward the testbench top
  output int                 pending,
  output int                 errors
);

  import stpg_pkg::*;

  localparam longint STEP_COUNT_MAX = 65535;

  typedef struct packed {
    logic        step_pin;
    logic        dir_pin;
    logic        enable_pin_n;
    logic [15:0] position;
    logic [15:0] steps;
    logic        busy;
  } pin_state_t;

  // Configuration copy
  logic [15:0]        high_ticks;
  logic [15:0]        step_period;
  logic signed [15:0] lower_bound;
  logic signed [15:0] upper_bound;

  // Motor state copy
  logic [POSITION_BITS-1:0] position_q;
  logic [15:0]              steps_q;
  logic [15:0]              countdown_q;
  logic                     pulse_q;
  logic                     active_q;
  logic                     dir_q;
  logic                     enabled_q;

  pin_state_t expected_pins[$];

  initial errors = 0;

  function automatic void reset_motor();
    high_ticks  = RESET_HIGH_TICKS;
    step_period = RESET_STEP_PERIOD;
    lower_bound = RESET_LOWER_BOUND;
    upper_bound = RESET_UPPER_BOUND;
    position_q  = '0;
    steps_q     = '0;
    countdown_q = '0;
    pulse_q     = 1'b0;
    active_q    = 1'b0;
    dir_q       = 1'b0;
    enabled_q   = 1'b0;
  endfunction

  // Clamp the request to the bounds and arm the timer when idle
  function automatic void plan_move(input logic dir, input logic [15:0] steps);
    longint pos;
    longint s;
    pos   = longint'($signed(position_q));
    s     = longint'(steps);
    dir_q = dir;
    if (dir) begin
      if (pos + s > longint'(upper_bound)) s = longint'(upper_bound) - pos;
    end else begin
      if (pos - s < longint'(lower_bound)) s = pos - longint'(lower_bound);
    end
    if (s < 0) s = 0;
    steps_q = s[15:0];
    if (!active_q) begin
      active_q    = 1'b1;
      countdown_q = 16'd1;
    end
  endfunction

  // Toggle the step pin on a compare event, or drop to idle
  function automatic void fire_phase();
    logic [15:0] ht;
    ht = (high_ticks != 16'd0) ? high_ticks : 16'd1;
    if (steps_q != 16'd0) begin
      if (pulse_q) begin
        pulse_q     = 1'b0;
        countdown_q = (step_period > ht) ? step_period - ht : 16'd1;
      end else begin
        pulse_q     = 1'b1;
        countdown_q = ht;
        steps_q     = steps_q - 16'd1;
        position_q  = dir_q ? position_q + 1'b1 : position_q - 1'b1;
      end
    end else begin
      pulse_q     = 1'b0;
      active_q    = 1'b0;
      countdown_q = '0;
    end
  endfunction

  // Advance the motor state by one input item and report the pins after it
  function automatic pin_state_t advance_motor(input logic [2:0] op,
                                               input logic dir,
                                               input logic [15:0] cnt,
                                               input logic signed [15:0] target,
                                               input logic en);
    pin_state_t r;
    longint     pos;
    longint     tgt;
    longint     span;
    case (op)
      OP_TICK: begin
        if (active_q) begin
          if (countdown_q <= 16'd1) fire_phase();
          else countdown_q = countdown_q - 16'd1;
        end
      end
      OP_MOVE: plan_move(dir, cnt);
      OP_GOTO: begin
        pos = longint'($signed(position_q));
        tgt = longint'(target);
        if (tgt != pos) begin
          span = (tgt > pos) ? tgt - pos : pos - tgt;
          if (span > STEP_COUNT_MAX) span = STEP_COUNT_MAX;
          plan_move(tgt > pos, span[15:0]);
        end
      end
      OP_ZERO:   position_q = '0;
      OP_ENABLE: enabled_q = en;
      default: ;
    endcase
    r.step_pin     = pulse_q;
    r.dir_pin      = dir_q;
    r.enable_pin_n = !enabled_q;
    r.position     = 16'(position_q);
    r.steps        = steps_q;
    r.busy         = active_q;
    return r;
  endfunction

  // Follow the channels: config writes, predictions, result compares
  always @(posedge clk) begin
    pin_state_t want;
    if (rst) begin
      reset_motor();
      expected_pins.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIGH_TICKS:  high_ticks  = cfg_data;
          CFG_STEP_PERIOD: step_period = cfg_data;
          CFG_LOWER_BOUND: lower_bound = cfg_data;
          CFG_UPPER_BOUND: upper_bound = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_pins.push_back(advance_motor(operation, move_dir, step_count,
                                              target_position, enable_flag));
      end
      if (out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errors++;
        end else begin
          want = expected_pins.pop_front();
          if (want.step_pin !== step_pin) begin
            $error("step_pin: expected %0d, actual %0d", want.step_pin, step_pin);
            errors++;
          end
          if (want.dir_pin !== dir_pin) begin
            $error("dir_pin: expected %0d, actual %0d", want.dir_pin, dir_pin);
            errors++;
          end
          if (want.enable_pin_n !== enable_pin_n) begin
            $error("enable_pin_n: expected %0d, actual %0d",
                   want.enable_pin_n, enable_pin_n);
            errors++;
          end
          if (want.position !== current_position) begin
            $error("current_position: expected %0d, actual %0d",
                   $signed(want.position), current_position);
            errors++;
          end
          if (want.steps !== steps_left) begin
            $error("steps_left: expected %0d, actual %0d", want.steps, steps_left);
            errors++;
          end
          if (want.busy !== busy_res) begin
            $error("busy_res: expected %0d, actual %0d", want.busy, busy_res);
            errors++;
          end
        end
      end
    end
    pending <= expected_pins.size();
  end

endmodule

// ===== tb/tb_stepper_step_pulse_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_step_pulse_generator: stimulus and verdict for the pulse generator
// Runs a directed sequence (enable, idle ticks, spare codes, zero-step and
// clamped moves, moves while busy, go-to at extremes) and then random traffic
// under several timing and bound settings, with bursty input, a varying
// result stall pattern and long result hold-offs. Checking is in stpg_checker.
// ----------------------------------------------------------------------------
module tb_stepper_step_pulse_generator;

  import stpg_pkg::*;

  localparam int          POSITION_BITS  = 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          LONG_STALL     = 400;
  localparam int          DRAIN_CYCLES   = 8;
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  typedef enum int {
    READY_ALWAYS,
    READY_SPARSE,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         operation = OP_TICK;
  logic               move_dir = 1'b0;
  logic [15:0]        step_count = '0;
  logic signed [15:0] target_position = '0;
  logic               enable_flag = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               step_pin;
  logic               dir_pin;
  logic               enable_pin_n;
  logic signed [15:0] current_position;
  logic [15:0]        steps_left;
  logic               busy_res;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_HIGH_TICKS;
  logic [15:0]        cfg_data = '0;

  int          pending;
  int          errors;
  int          burst_left = 0;
  int          items_sent = 0;
  int          stall_req = 0;
  int          stall_served = 0;
  int          stall_left = 0;
  int          mode_left = 0;
  int          idle_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  stepper_step_pulse_generator #(
    .POSITION_BITS(POSITION_BITS)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .move_dir(move_dir), .step_count(step_count),
    .target_position(target_position), .enable_flag(enable_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .step_pin(step_pin), .dir_pin(dir_pin), .enable_pin_n(enable_pin_n),
    .current_position(current_position), .steps_left(steps_left),
    .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stpg_checker #(
    .POSITION_BITS(POSITION_BITS)
  ) i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .move_dir(move_dir), .step_count(step_count),
    .target_position(target_position), .enable_flag(enable_flag),
    .out_valid(out_valid), .out_ready(out_ready),
    .step_pin(step_pin), .dir_pin(dir_pin), .enable_pin_n(enable_pin_n),
    .current_position(current_position), .steps_left(steps_left),
    .busy_res(busy_res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Drive result ready: long hold-offs on request, otherwise a randomly chosen ready mode
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_served) begin
      stall_served <= stall_req;
      stall_left   <= LONG_STALL;
      out_ready    <= 1'b0;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:      out_ready <= ((mode_left % 5) < 3);
      endcase
    end
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one item, sometimes opening a random gap before a new burst
  task automatic send_item(input logic [2:0] op, input logic dir,
                           input logic [15:0] cnt, input logic [15:0] tgt,
                           input logic en);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    operation       <= op;
    move_dir        <= dir;
    step_count      <= cnt;
    target_position <= tgt;
    enable_flag     <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; valid stays high between them
  task automatic program_motion(input logic [15:0] ht, input logic [15:0] period,
                                input logic [15:0] lo, input logic [15:0] hi);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{CFG_HIGH_TICKS, CFG_STEP_PERIOD, CFG_LOWER_BOUND, CFG_UPPER_BOUND};
    vals = '{ht, period, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Tick runs half the time; moves, go-tos, zero, enable and spare codes otherwise
  task automatic random_item();
    int          pick;
    logic [15:0] cnt;
    logic [15:0] tgt;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      repeat ($urandom_range(1, 12))
        send_item(OP_TICK, 1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (pick < 64) begin
      cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      send_item(OP_MOVE, 1'($urandom), cnt, 16'($urandom), 1'($urandom));
    end else if (pick < 78) begin
      tgt = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                        : 16'(int'($urandom_range(0, 40)) - 20);
      send_item(OP_GOTO, 1'($urandom), 16'($urandom), tgt, 1'($urandom));
    end else if (pick < 86) begin
      send_item(OP_ZERO, 1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (pick < 96) begin
      send_item(OP_ENABLE, 1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 1'($urandom),
                16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  // Reprogram while idle, optionally request a long hold-off, then random traffic
  task automatic run_phase(input logic [15:0] ht, input logic [15:0] period,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input int count, input bit hold_off);
    int start;
    drain();
    program_motion(ht, period, lo, hi);
    if (hold_off) stall_req <= stall_req + 1;
    start = items_sent;
    while (items_sent - start < count) random_item();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: enable pin, idle tick, spare codes, go-to in place,
    // zero-step move that goes idle on the next tick
    send_item(OP_ENABLE, 1'b0, 16'd0, 16'd0, 1'b1);
    send_item(OP_ENABLE, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_SPARE_FIRST, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_SPARE_LAST, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_GOTO, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_MOVE, 1'b1, 16'd0, 16'd0, 1'b0);
    send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);

    // High time over period, position below the lower bound
    drain();
    program_motion(16'd3, 16'd2, 16'd5, 16'd10);
    send_item(OP_MOVE, 1'b0, 16'd4, 16'd0, 1'b0);
    send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_MOVE, 1'b1, 16'd40, 16'd0, 1'b0);
    repeat (4) send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_MOVE, 1'b0, 16'd1, 16'd0, 1'b0);
    repeat (2) send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_GOTO, 1'b0, 16'd0, 16'h8000, 1'b0);
    send_item(OP_GOTO, 1'b0, 16'd0, 16'h7FFF, 1'b0);
    repeat (3) send_item(OP_TICK, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_ZERO, 1'b0, 16'd0, 16'd0, 1'b0);
    send_item(OP_ENABLE, 1'b0, 16'd0, 16'd0, 1'b1);
    send_item(OP_MOVE, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);

    // Random traffic over a spread of timings and bounds
    run_phase(16'd1, 16'd2, 16'h8000, 16'h7FFF, 200, 1'b1);
    run_phase(16'd3, 16'd2, 16'(-10), 16'd10, 180, 1'b0);
    run_phase(16'd2, 16'd5, 16'd0, 16'd0, 100, 1'b0);
    run_phase(16'd4, 16'd9, 16'd8, 16'(-8), 80, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 60, 1'b0);
    run_phase(16'd1, 16'hFFFF, 16'(-20), 16'd20, 60, 1'b0);
    run_phase(16'd2, 16'd7, 16'h8000, 16'h7FFF, 320, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
